// ===== hw/rtl/servo_slew_controller_macros.svh =====
// Assertion helpers for the servo slew controller.
`ifndef SERVO_SLEW_CONTROLLER_MACROS_SVH
`define SERVO_SLEW_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("servo slew controller: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("servo slew controller: next-cycle check failed");

`endif

// ===== hw/rtl/ssc_pkg.sv =====
package ssc_pkg;

   localparam int NUM_CHANNELS = 16;
   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   localparam int OP_W = 2;
   localparam int CH_W = 4;
   localparam int ANGLE_W = 8;
   localparam int PWM_W = 12;
   localparam int PULSE_W = 13;
   localparam int TIME_W = 16;
   localparam int MS_W = 8;
   localparam int USED_W = 5;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W = 16;

   localparam int REQ_FIELD_W = CH_W + 2;
   localparam int REQ_DATA_W = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = CH_W + PULSE_W + 1;
   localparam int RSP_DATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [ANGLE_W-1:0] RESET_ANGLE = 8'd90;
   localparam logic [ANGLE_W-1:0] RESET_ANGLE_A = 8'd0;
   localparam logic [ANGLE_W-1:0] RESET_ANGLE_B = 8'd180;
   localparam logic [MS_W-1:0] RESET_STEP_INTERVAL = 8'd20;
   localparam logic [TIME_W-1:0] RESET_AUTO_OFF = 16'd1000;
   localparam logic [PWM_W-1:0] RESET_PULSE_MIN = 12'd150;
   localparam logic [PWM_W-1:0] RESET_PULSE_MAX = 12'd600;
   localparam logic [USED_W-1:0] RESET_CHANNELS_USED = 5'd16;

   localparam logic [MS_W-1:0] MS_MAX = '1;
   localparam logic [PWM_W-1:0] PWM_MAX = '1;
   localparam logic [PULSE_W-1:0] FULL_OFF = 13'd4096;

   localparam int ANGLE_SPAN = 180;
   localparam int RECIP_SHIFT = 28;
   localparam int RECIP_W = 21;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / ANGLE_SPAN);
   localparam int PIPE_DEPTH = 4;

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 2'd0,
      OP_SET   = 2'd1,
      OP_QUERY = 2'd2,
      OP_START = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANGLE_A       = 3'd0,
      CSR_ANGLE_B       = 3'd1,
      CSR_STEP_INTERVAL = 3'd2,
      CSR_AUTO_OFF      = 3'd3,
      CSR_PULSE_MIN     = 3'd4,
      CSR_PULSE_MAX     = 3'd5,
      CSR_CHANNELS_USED = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_MOVE,
      ACT_OFF
   } act_type;

   typedef enum logic [1:0] {
      EMIT_PULSE,
      EMIT_OFF,
      EMIT_REPORT
   } emit_sel_type;

   typedef struct packed {
      logic         accept;
      logic         tick_eval;
      logic         start_eval;
      logic         set_eval;
      logic         next;
      logic         emit;
      emit_sel_type emit_sel;
      logic         flush;
   } cmd_type;

   typedef struct packed {
      op_type  op;
      logic    power;
      logic    tick_go;
      logic    ch_ok;
      logic    none_served;
      logic    idx_last;
      act_type act;
      logic    can_emit;
   } status_type;

   typedef struct packed {
      logic               kind;
      logic [CH_W-1:0]    channel;
      logic [PULSE_W-1:0] pulse;
      logic               position;
   } result_type;

endpackage

// ===== hw/rtl/servo_slew_controller.sv =====
// Slew-limited controller for up to sixteen servo channels. Each input word is a
// millisecond tick, a set, a query or a start command; each output word is either a
// pulse width update or a position report, and tlast marks the final output word of
// an input word. Words are handled one at a time. A tick that does not reach the step
// interval, or a set or query of a channel that does not exist, gives nothing. A tick
// that sweeps visits every served channel, one that neither moves nor turns off as
// well as one that turns off or moves, and a start visits every served channel too.
// Moving channels and every channel of a start go through the four-stage pulse
// width pipeline (multiply, reciprocal multiply for the division by 180, correction,
// offset and saturation) that one sequencer shares across all channels. A stalled
// output adds its stall time. Configuration is to be written through the csr port
// only while the block is idle; the block itself does not enforce this. Indexes
// beyond the last register are ignored.
`include "servo_slew_controller_macros.svh"

module servo_slew_controller (
   input  logic                           clock,
   input  logic                           reset,
   // tdata: channel [3:0], dir [4], power [5], zero fill [7:6]
   input  logic [ssc_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: op [1:0]
   input  logic [ssc_pkg::OP_W-1:0]       req_tuser,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tdata: out_channel [3:0], pulse [16:4], position [17], zero fill [23:18]
   output logic [ssc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser: kind [0]
   output logic                           rsp_tuser,
   output logic                           rsp_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic                           csr_we,
   input  logic [ssc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssc_pkg::CSR_W-1:0]      csr_wdata
);
   import ssc_pkg::*;

   cmd_type    cmd;
   status_type status;

   ssc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ssc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `SSC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `SSC_ASSERT_SAME(a_report_has_no_pulse, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[16:4] == '0)
   `SSC_ASSERT_SAME(a_update_in_range, clock, reset, rsp_tvalid && !rsp_tuser, !rsp_tdata[17] && (rsp_tdata[16:4] <= FULL_OFF))

endmodule

// ===== hw/rtl/ssc_pulse.sv =====
module ssc_pulse (
   input  logic                        clock,
   input  logic [ssc_pkg::ANGLE_W-1:0] angle,
   input  logic [ssc_pkg::PWM_W-1:0]   pulse_min,
   input  logic [ssc_pkg::PWM_W-1:0]   pulse_max,
   output logic [ssc_pkg::PULSE_W-1:0] pulse
);
   import ssc_pkg::*;

   localparam int MAG_W = ANGLE_W + PWM_W;
   localparam int Q_W = MAG_W - $clog2(ANGLE_SPAN) + 1;
   localparam int SCALED_W = MAG_W + RECIP_W;
   localparam int SUM_W = Q_W + 2;

   logic                    span_neg;
   logic [PWM_W-1:0]        span_mag;
   logic [MAG_W-1:0]        mag_in, mag_ff, mag2_ff;
   logic [SCALED_W-1:0]     scaled;
   logic [Q_W-1:0]          qraw_in, qraw_ff;
   logic [MAG_W-1:0]        rem;
   logic [Q_W-1:0]          qfix_in, qfix_ff;
   logic signed [SUM_W-1:0] base, qsigned, sum;
   logic [PULSE_W-1:0]      pulse_in, pulse_ff;

   // The sign of the span is taken out so that the quotient truncates toward zero.
   assign span_neg = pulse_max < pulse_min;
   assign span_mag = span_neg ? pulse_min - pulse_max : pulse_max - pulse_min;
   assign mag_in = MAG_W'(angle) * MAG_W'(span_mag);

   // Reciprocal estimate is never high and at most one low; one correction fixes it.
   assign scaled = SCALED_W'(mag_ff) * SCALED_W'(RECIP);
   assign qraw_in = scaled[RECIP_SHIFT +: Q_W];
   assign rem = mag2_ff - MAG_W'(qraw_ff) * MAG_W'(ANGLE_SPAN);
   assign qfix_in = (rem >= MAG_W'(ANGLE_SPAN)) ? qraw_ff + Q_W'(1) : qraw_ff;

   assign base = $signed({{(SUM_W-PWM_W){1'b0}}, pulse_min});
   assign qsigned = $signed({{(SUM_W-Q_W){1'b0}}, qfix_ff});
   assign sum = span_neg ? base - qsigned : base + qsigned;

   always_comb begin
      if (sum[SUM_W-1]) begin
         pulse_in = '0;
      end else if (sum[SUM_W-2:PWM_W] != '0) begin
         pulse_in = PULSE_W'(PWM_MAX);
      end else begin
         pulse_in = PULSE_W'(sum[PWM_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      mag2_ff <= mag_ff;
      qraw_ff <= qraw_in;
      qfix_ff <= qfix_in;
      pulse_ff <= pulse_in;
   end

   assign pulse = pulse_ff;

endmodule

// ===== hw/rtl/ssc_datapath.sv =====
module ssc_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ssc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssc_pkg::CSR_W-1:0]      csr_wdata,
   input  logic [ssc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [ssc_pkg::OP_W-1:0]       req_tuser,
   input  ssc_pkg::cmd_type               cmd,
   output ssc_pkg::status_type            status,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ssc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser,
   output logic                           rsp_tlast
);
   import ssc_pkg::*;

   logic [ANGLE_W-1:0] angle_a_ff, angle_b_ff;
   logic [MS_W-1:0]    step_interval_ff;
   logic [TIME_W-1:0]  auto_off_ff;
   logic [PWM_W-1:0]   pulse_min_ff, pulse_max_ff;
   logic [USED_W-1:0]  channels_used_ff;

   op_type             op_ff;
   logic               dir_ff, power_ff, ch_ok_ff, tick_go_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [MS_W-1:0]    ms_ff, elapsed_ff, ms_in;
   logic               tick_go_in;

   logic [ANGLE_W-1:0] cur_ff [NUM_CHANNELS];
   logic [ANGLE_W-1:0] goal_ff [NUM_CHANNELS];
   logic               drv_ff [NUM_CHANNELS];
   logic [TIME_W-1:0]  cnt_ff [NUM_CHANNELS];

   logic [ANGLE_W-1:0] cur_rd, goal_rd, step_ang, mid_ang, ang_ff;
   logic               drv_rd, moving, timed, fire;
   logic [TIME_W-1:0]  cnt_rd, elapsed_ext;
   logic [ANGLE_W:0]   angle_sum;
   logic [USED_W-1:0]  n_served;
   logic [PULSE_W-1:0] pulse_calc;
   logic               rpt_pos;
   act_type            act;

   result_type         new_res, hold_ff, rsp_ff;
   logic               hold_v_ff, rsp_v_ff, rsp_last_ff, out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_a_ff <= RESET_ANGLE_A;
         angle_b_ff <= RESET_ANGLE_B;
         step_interval_ff <= RESET_STEP_INTERVAL;
         auto_off_ff <= RESET_AUTO_OFF;
         pulse_min_ff <= RESET_PULSE_MIN;
         pulse_max_ff <= RESET_PULSE_MAX;
         channels_used_ff <= RESET_CHANNELS_USED;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ANGLE_A: angle_a_ff <= csr_wdata[ANGLE_W-1:0];
            CSR_ANGLE_B: angle_b_ff <= csr_wdata[ANGLE_W-1:0];
            CSR_STEP_INTERVAL: step_interval_ff <= csr_wdata[MS_W-1:0];
            CSR_AUTO_OFF: auto_off_ff <= csr_wdata[TIME_W-1:0];
            CSR_PULSE_MIN: pulse_min_ff <= csr_wdata[PWM_W-1:0];
            CSR_PULSE_MAX: pulse_max_ff <= csr_wdata[PWM_W-1:0];
            CSR_CHANNELS_USED: channels_used_ff <= csr_wdata[USED_W-1:0];
            default: ;
         endcase
      end
   end

   assign ms_in = (ms_ff == MS_MAX) ? ms_ff : ms_ff + MS_W'(1);
   assign tick_go_in = ms_in >= step_interval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_ff <= '0;
         op_ff <= OP_TICK;
         dir_ff <= 1'b0;
         power_ff <= 1'b0;
         ch_ok_ff <= 1'b0;
         tick_go_ff <= 1'b0;
         elapsed_ff <= '0;
         idx_ff <= '0;
      end else if (cmd.accept) begin
         op_ff <= op_type'(req_tuser);
         dir_ff <= req_tdata[CH_W];
         power_ff <= req_tdata[CH_W+1];
         ch_ok_ff <= (USED_W'(req_tdata[CH_W-1:0]) < USED_W'(NUM_CHANNELS));
         if (op_type'(req_tuser) == OP_SET || op_type'(req_tuser) == OP_QUERY) begin
            idx_ff <= req_tdata[IDX_W-1:0];
         end else begin
            idx_ff <= '0;
         end
         if (op_type'(req_tuser) == OP_TICK) begin
            ms_ff <= tick_go_in ? '0 : ms_in;
            elapsed_ff <= ms_in;
            tick_go_ff <= tick_go_in;
         end
      end else if (cmd.next) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   assign cur_rd = cur_ff[idx_ff];
   assign goal_rd = goal_ff[idx_ff];
   assign drv_rd = drv_ff[idx_ff];
   assign cnt_rd = cnt_ff[idx_ff];

   assign elapsed_ext = TIME_W'(elapsed_ff);
   assign moving = cur_rd != goal_rd;
   assign step_ang = (goal_rd > cur_rd) ? cur_rd + ANGLE_W'(1) : cur_rd - ANGLE_W'(1);
   assign timed = drv_rd && (auto_off_ff != '0);
   assign fire = cnt_rd <= elapsed_ext;
   assign angle_sum = (ANGLE_W+1)'(angle_a_ff) + (ANGLE_W+1)'(angle_b_ff);
   assign mid_ang = angle_sum[ANGLE_W:1];

   always_comb begin
      if (moving) begin
         act = ACT_MOVE;
      end else if (timed && fire) begin
         act = ACT_OFF;
      end else begin
         act = ACT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            cur_ff[i] <= RESET_ANGLE;
            goal_ff[i] <= RESET_ANGLE;
            drv_ff[i] <= 1'b0;
            cnt_ff[i] <= '0;
         end
      end else if (cmd.tick_eval) begin
         if (moving) begin
            cur_ff[idx_ff] <= step_ang;
            drv_ff[idx_ff] <= 1'b1;
            cnt_ff[idx_ff] <= auto_off_ff;
         end else if (timed) begin
            if (fire) begin
               cnt_ff[idx_ff] <= '0;
               drv_ff[idx_ff] <= 1'b0;
            end else begin
               cnt_ff[idx_ff] <= cnt_rd - elapsed_ext;
            end
         end
      end else if (cmd.start_eval) begin
         cur_ff[idx_ff] <= mid_ang;
         goal_ff[idx_ff] <= angle_a_ff;
      end else if (cmd.set_eval) begin
         if (power_ff) begin
            goal_ff[idx_ff] <= dir_ff ? angle_b_ff : angle_a_ff;
         end else begin
            goal_ff[idx_ff] <= cur_rd;
            drv_ff[idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tick_eval) begin
         ang_ff <= step_ang;
      end else if (cmd.start_eval) begin
         ang_ff <= mid_ang;
      end
   end

   ssc_pulse u_pulse (
      .clock     (clock),
      .angle     (ang_ff),
      .pulse_min (pulse_min_ff),
      .pulse_max (pulse_max_ff),
      .pulse     (pulse_calc)
   );

   always_comb begin
      case (op_ff)
         OP_SET: rpt_pos = dir_ff;
         OP_QUERY: rpt_pos = goal_rd != angle_a_ff;
         default: rpt_pos = 1'b0;
      endcase
   end

   always_comb begin
      new_res.channel = CH_W'(idx_ff);
      case (cmd.emit_sel)
         EMIT_PULSE: begin
            new_res.kind = 1'b0;
            new_res.pulse = pulse_calc;
            new_res.position = 1'b0;
         end
         EMIT_OFF: begin
            new_res.kind = 1'b0;
            new_res.pulse = FULL_OFF;
            new_res.position = 1'b0;
         end
         EMIT_REPORT: begin
            new_res.kind = 1'b1;
            new_res.pulse = '0;
            new_res.position = rpt_pos;
         end
         default: begin
            new_res.kind = 1'b0;
            new_res.pulse = '0;
            new_res.position = 1'b0;
         end
      endcase
   end

   // One word is held back so the final word of an item can be marked last.
   assign out_free = !rsp_v_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
         rsp_last_ff <= 1'b0;
      end else if (cmd.emit) begin
         hold_ff <= new_res;
         hold_v_ff <= 1'b1;
         if (hold_v_ff) begin
            rsp_ff <= hold_ff;
            rsp_last_ff <= 1'b0;
            rsp_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_v_ff <= 1'b0;
         end
      end else if (cmd.flush && hold_v_ff) begin
         rsp_ff <= hold_ff;
         rsp_last_ff <= 1'b1;
         rsp_v_ff <= 1'b1;
         hold_v_ff <= 1'b0;
      end else if (rsp_tready) begin
         rsp_v_ff <= 1'b0;
      end
   end

   assign n_served = (channels_used_ff > USED_W'(NUM_CHANNELS)) ?
                     USED_W'(NUM_CHANNELS) : channels_used_ff;

   assign status.op = op_ff;
   assign status.power = power_ff;
   assign status.tick_go = tick_go_ff;
   assign status.ch_ok = ch_ok_ff;
   assign status.none_served = n_served == '0;
   assign status.idx_last = (USED_W'(idx_ff) + USED_W'(1)) == n_served;
   assign status.act = act;
   assign status.can_emit = !hold_v_ff || out_free;

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata = {{(RSP_DATA_W-RSP_FIELD_W){1'b0}},
                       rsp_ff.position, rsp_ff.pulse, rsp_ff.channel};
   assign rsp_tuser = rsp_ff.kind;
   assign rsp_tlast = rsp_last_ff;

endmodule

// ===== hw/rtl/ssc_ctrl.sv =====
module ssc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  ssc_pkg::status_type status,
   output ssc_pkg::cmd_type    cmd
);
   import ssc_pkg::*;

   localparam int WAIT_W = (PIPE_DEPTH > 1) ? $clog2(PIPE_DEPTH) : 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_TICK_EVAL,
      ST_START_EVAL,
      ST_SET,
      ST_WAIT,
      ST_EMIT_PULSE,
      ST_EMIT_OFF,
      ST_EMIT_RPT,
      ST_NEXT,
      ST_FLUSH
   } state_type;

   state_type         state_ff, state_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;

   always_comb begin
      state_in = state_ff;
      wait_in = wait_ff;
      cmd = '0;
      req_tready = state_ff == ST_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.op)
               OP_TICK: begin
                  state_in = (status.tick_go && !status.none_served) ? ST_TICK_EVAL : ST_IDLE;
               end
               OP_SET: state_in = status.ch_ok ? ST_SET : ST_IDLE;
               OP_QUERY: state_in = status.ch_ok ? ST_EMIT_RPT : ST_IDLE;
               OP_START: state_in = status.none_served ? ST_IDLE : ST_START_EVAL;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_TICK_EVAL: begin
            cmd.tick_eval = 1'b1;
            wait_in = '0;
            case (status.act)
               ACT_MOVE: state_in = ST_WAIT;
               ACT_OFF: state_in = ST_EMIT_OFF;
               default: state_in = ST_NEXT;
            endcase
         end
         ST_START_EVAL: begin
            cmd.start_eval = 1'b1;
            wait_in = '0;
            state_in = ST_WAIT;
         end
         ST_SET: begin
            cmd.set_eval = 1'b1;
            state_in = status.power ? ST_EMIT_RPT : ST_EMIT_OFF;
         end
         ST_WAIT: begin
            if (wait_ff == WAIT_W'(PIPE_DEPTH - 1)) begin
               state_in = ST_EMIT_PULSE;
            end else begin
               wait_in = wait_ff + WAIT_W'(1);
            end
         end
         ST_EMIT_PULSE: begin
            cmd.emit_sel = EMIT_PULSE;
            if (status.can_emit) begin
               cmd.emit = 1'b1;
               state_in = (status.op == OP_START) ? ST_EMIT_RPT : ST_NEXT;
            end
         end
         ST_EMIT_OFF: begin
            cmd.emit_sel = EMIT_OFF;
            if (status.can_emit) begin
               cmd.emit = 1'b1;
               state_in = (status.op == OP_TICK) ? ST_NEXT : ST_FLUSH;
            end
         end
         ST_EMIT_RPT: begin
            cmd.emit_sel = EMIT_REPORT;
            if (status.can_emit) begin
               cmd.emit = 1'b1;
               state_in = (status.op == OP_START) ? ST_NEXT : ST_FLUSH;
            end
         end
         ST_NEXT: begin
            if (status.idx_last) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.next = 1'b1;
               state_in = (status.op == OP_START) ? ST_START_EVAL : ST_TICK_EVAL;
            end
         end
         ST_FLUSH: begin
            if (status.can_emit) begin
               cmd.flush = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff <= wait_in;
      end
   end

endmodule

// ===== sim/tb_servo_slew_controller.sv =====
`timescale 1ns / 1ps

module tb_servo_slew_controller;
   import ssc_pkg::*;

   localparam logic KIND_PULSE  = 1'b0;
   localparam logic KIND_REPORT = 1'b1;
   localparam int SETTLE_CYCLES = 64;
   localparam int MAX_REPORTED  = 10;

   typedef struct {
      result_type word;
      logic       last;
   } servo_word_type;

   class servo_tracker;
      logic [ANGLE_W-1:0] angle_a;
      logic [ANGLE_W-1:0] angle_b;
      logic [MS_W-1:0]    step_interval;
      logic [TIME_W-1:0]  auto_off_time;
      logic [PWM_W-1:0]   pulse_min;
      logic [PWM_W-1:0]   pulse_max;
      logic [USED_W-1:0]  channels_used;
      logic [MS_W-1:0]    ms_since_move;
      logic [ANGLE_W-1:0] current_angle[NUM_CHANNELS];
      logic [ANGLE_W-1:0] goal_angle[NUM_CHANNELS];
      bit                 driving[NUM_CHANNELS];
      int unsigned        off_countdown[NUM_CHANNELS];
      servo_word_type     pending_words[$];
      int                 predicted;
      int                 mismatches;

      function new();
         int i;
         angle_a       = RESET_ANGLE_A;
         angle_b       = RESET_ANGLE_B;
         step_interval = RESET_STEP_INTERVAL;
         auto_off_time = RESET_AUTO_OFF;
         pulse_min     = RESET_PULSE_MIN;
         pulse_max     = RESET_PULSE_MAX;
         channels_used = RESET_CHANNELS_USED;
         ms_since_move = '0;
         for (i = 0; i < NUM_CHANNELS; i++) begin
            current_angle[i] = RESET_ANGLE;
            goal_angle[i]    = RESET_ANGLE;
            driving[i]       = 1'b0;
            off_countdown[i] = 0;
         end
         predicted  = 0;
         mismatches = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_W-1:0] value);
         case (idx)
            CSR_ANGLE_A:       angle_a = value[ANGLE_W-1:0];
            CSR_ANGLE_B:       angle_b = value[ANGLE_W-1:0];
            CSR_STEP_INTERVAL: step_interval = value[MS_W-1:0];
            CSR_AUTO_OFF:      auto_off_time = value[TIME_W-1:0];
            CSR_PULSE_MIN:     pulse_min = value[PWM_W-1:0];
            CSR_PULSE_MAX:     pulse_max = value[PWM_W-1:0];
            CSR_CHANNELS_USED: channels_used = value[USED_W-1:0];
            default: ;
         endcase
      endfunction

      function int served_count();
         return (channels_used > NUM_CHANNELS) ? NUM_CHANNELS : int'(channels_used);
      endfunction

      function logic [PULSE_W-1:0] pulse_for(int angle);
         int span;
         int width;
         span  = int'(pulse_max) - int'(pulse_min);
         width = int'(pulse_min) + (angle * span) / ANGLE_SPAN;
         if (width < 0) width = 0;
         if (width > int'(PWM_MAX)) width = int'(PWM_MAX);
         return PULSE_W'(width);
      endfunction

      function void add_word(logic kind, int ch, logic [PULSE_W-1:0] pulse, logic pos);
         servo_word_type w;
         w.word.kind     = kind;
         w.word.channel  = CH_W'(ch);
         w.word.pulse    = pulse;
         w.word.position = pos;
         w.last          = 1'b0;
         pending_words.push_back(w);
         predicted++;
      endfunction

      function void accept_command(op_type op, logic [CH_W-1:0] ch, logic dir, logic power);
         int          i;
         int          first;
         int          mid;
         int unsigned elapsed;
         first = pending_words.size();
         case (op)
            OP_TICK: begin
               if (ms_since_move < MS_MAX) ms_since_move++;
               if (ms_since_move >= step_interval) begin
                  elapsed = ms_since_move;
                  ms_since_move = '0;
                  for (i = 0; i < served_count(); i++) begin
                     if (current_angle[i] != goal_angle[i]) begin
                        if (goal_angle[i] > current_angle[i]) current_angle[i]++;
                        else current_angle[i]--;
                        add_word(KIND_PULSE, i, pulse_for(current_angle[i]), 1'b0);
                        driving[i] = 1'b1;
                        off_countdown[i] = auto_off_time;
                     end else if (driving[i] && auto_off_time != 0) begin
                        if (off_countdown[i] <= elapsed) begin
                           off_countdown[i] = 0;
                           driving[i] = 1'b0;
                           add_word(KIND_PULSE, i, FULL_OFF, 1'b0);
                        end else begin
                           off_countdown[i] -= elapsed;
                        end
                     end
                  end
               end
            end
            OP_SET: begin
               if (power) begin
                  goal_angle[ch] = dir ? angle_b : angle_a;
                  add_word(KIND_REPORT, ch, '0, dir);
               end else begin
                  add_word(KIND_PULSE, ch, FULL_OFF, 1'b0);
                  goal_angle[ch] = current_angle[ch];
                  driving[ch] = 1'b0;
               end
            end
            OP_QUERY: begin
               add_word(KIND_REPORT, ch, '0, (goal_angle[ch] == angle_a) ? 1'b0 : 1'b1);
            end
            OP_START: begin
               mid = (int'(angle_a) + int'(angle_b)) / 2;
               for (i = 0; i < served_count(); i++) begin
                  current_angle[i] = ANGLE_W'(mid);
                  add_word(KIND_PULSE, i, pulse_for(mid), 1'b0);
                  goal_angle[i] = angle_a;
                  add_word(KIND_REPORT, i, '0, 1'b0);
               end
            end
            default: ;
         endcase
         if (pending_words.size() > first)
            pending_words[pending_words.size() - 1].last = 1'b1;
      endfunction

      function void check_word(logic kind, logic [CH_W-1:0] ch, logic [PULSE_W-1:0] pulse,
                               logic pos, logic last);
         servo_word_type w;
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED)
               $display("%0t: unexpected word: kind %0d channel %0d pulse %0d %s %0d %0d",
                        $time, kind, ch, pulse, "position/last", pos, last);
            return;
         end
         w = pending_words.pop_front();
         if (kind !== w.word.kind || ch !== w.word.channel || pulse !== w.word.pulse ||
             pos !== w.word.position || last !== w.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED) begin
               $display("%0t: word mismatch: expected kind %0d channel %0d pulse %0d %s %0d %0d",
                        $time, w.word.kind, w.word.channel, w.word.pulse, "position/last",
                        w.word.position, w.last);
               $display("%0t:                got kind %0d channel %0d pulse %0d %s %0d %0d",
                        $time, kind, ch, pulse, "position/last", pos, last);
            end
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [OP_W-1:0]       req_tuser;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_W-1:0]      csr_wdata;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;

   servo_tracker tracker = new();

   servo_slew_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(20_000_000);
      $display("** servo_slew_controller: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Results are checked before the new command is noted, so that a word
   // accepted on the same edge can never be matched against its own results.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            tracker.check_word(rsp_tuser, rsp_tdata[CH_W-1:0], rsp_tdata[CH_W +: PULSE_W],
                               rsp_tdata[CH_W + PULSE_W], rsp_tlast);
         if (req_tvalid && req_tready)
            tracker.accept_command(op_type'(req_tuser), req_tdata[CH_W-1:0],
                                   req_tdata[CH_W], req_tdata[CH_W + 1]);
      end
   end

   task automatic send_command(op_type op, logic [CH_W-1:0] ch, logic dir, logic power);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'({power, dir, ch});
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic program_reg(csr_index_type idx, int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(value);
      tracker.write_reg(idx, CSR_W'(value));
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_settings();
      int a;
      int b;
      a = $urandom_range(180);
      if ($urandom_range(5) == 0) begin
         b = $urandom_range(255);
      end else begin
         b = a + $urandom_range(12) - 6;
         if (b < 0) b = 0;
      end
      program_reg(CSR_ANGLE_A, a);
      program_reg(CSR_ANGLE_B, b);
      case ($urandom_range(7))
         0: program_reg(CSR_STEP_INTERVAL, 255);
         1: program_reg(CSR_STEP_INTERVAL, $urandom_range(20, 4));
         default: program_reg(CSR_STEP_INTERVAL, $urandom_range(3));
      endcase
      case ($urandom_range(7))
         0: program_reg(CSR_AUTO_OFF, 0);
         1: program_reg(CSR_AUTO_OFF, 65535);
         2: program_reg(CSR_AUTO_OFF, $urandom_range(65535));
         default: program_reg(CSR_AUTO_OFF, $urandom_range(12, 1));
      endcase
      program_reg(CSR_PULSE_MIN, $urandom_range(4095));
      program_reg(CSR_PULSE_MAX, $urandom_range(4095));
      case ($urandom_range(9))
         0: program_reg(CSR_CHANNELS_USED, 0);
         1: program_reg(CSR_CHANNELS_USED, $urandom_range(31, 17));
         default: program_reg(CSR_CHANNELS_USED, $urandom_range(16, 1));
      endcase
   endtask

   task automatic random_command();
      int              roll;
      int              span;
      logic [CH_W-1:0] ch;
      roll = $urandom_range(99);
      span = tracker.served_count();
      if (span > 0 && $urandom_range(4) != 0) ch = CH_W'($urandom_range(span - 1));
      else ch = CH_W'($urandom_range(NUM_CHANNELS - 1));
      if (roll < 62)
         send_command(OP_TICK, ch, 1'($urandom), 1'($urandom));
      else if (roll < 84)
         send_command(OP_SET, ch, 1'($urandom), ($urandom_range(4) != 0));
      else if (roll < 93)
         send_command(OP_QUERY, ch, 1'($urandom), 1'($urandom));
      else
         send_command(OP_START, ch, 1'($urandom), 1'($urandom));
   endtask

   task automatic random_phase(int words);
      int base;
      int n;
      base = tracker.predicted;
      n = 0;
      while (n < words || (tracker.predicted - base < 12 && n < 4 * words)) begin
         random_command();
         n++;
      end
   endtask

   initial begin
      int mode;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_TICK;
      csr_we     <= 1'b0;
      csr_index  <= CSR_ANGLE_A;
      csr_wdata  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every tick sweeps, with a short auto-off and full pulse range.
      program_reg(CSR_STEP_INTERVAL, 0);
      program_reg(CSR_AUTO_OFF, 2);
      program_reg(CSR_PULSE_MIN, 0);
      program_reg(CSR_PULSE_MAX, 4095);
      send_command(OP_QUERY, 4'd0, 1'b0, 1'b0);
      send_command(OP_QUERY, 4'd15, 1'b1, 1'b1);
      send_command(OP_SET, 4'd0, 1'b1, 1'b1);
      send_command(OP_SET, 4'd15, 1'b0, 1'b1);
      send_command(OP_SET, 4'd9, 1'b1, 1'b0);
      send_command(OP_TICK, 4'd0, 1'b0, 1'b0);
      send_command(OP_TICK, 4'd15, 1'b1, 1'b1);
      send_command(OP_START, 4'd0, 1'b0, 1'b0);
      send_command(OP_TICK, 4'd0, 1'b0, 1'b0);
      send_command(OP_SET, 4'd15, 1'b0, 1'b0);
      send_command(OP_TICK, 4'd0, 1'b0, 1'b0);
      settle();

      // Angles past 180 with reversed limits drive the pulse below zero.
      program_reg(CSR_ANGLE_A, 255);
      program_reg(CSR_ANGLE_B, 250);
      program_reg(CSR_PULSE_MIN, 4095);
      program_reg(CSR_PULSE_MAX, 0);
      program_reg(CSR_CHANNELS_USED, 2);
      send_command(OP_START, 4'd0, 1'b0, 1'b0);
      repeat (6) send_command(OP_TICK, 4'd0, 1'b0, 1'b0);
      send_command(OP_SET, 4'd1, 1'b1, 1'b1);
      send_command(OP_QUERY, 4'd1, 1'b0, 1'b0);
      send_command(OP_QUERY, 4'd0, 1'b0, 1'b0);
      settle();

      // Served count above the channel total, pulse above full scale, then no served channels.
      program_reg(CSR_CHANNELS_USED, 31);
      program_reg(CSR_PULSE_MIN, 100);
      program_reg(CSR_PULSE_MAX, 4095);
      program_reg(CSR_AUTO_OFF, 0);
      send_command(OP_START, 4'd0, 1'b0, 1'b0);
      send_command(OP_TICK, 4'd0, 1'b0, 1'b0);
      settle();
      program_reg(CSR_CHANNELS_USED, 0);
      send_command(OP_START, 4'd0, 1'b0, 1'b0);
      send_command(OP_TICK, 4'd0, 1'b0, 1'b0);
      settle();

      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               tx_idle_pct = 31;
               rx_idle_pct = 84;
            end
            1: begin
               tx_idle_pct = 84;
               rx_idle_pct = 31;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         repeat (2) begin
            random_settings();
            random_phase(30);
            settle();
         end
      end

      if (tracker.mismatches == 0 && tracker.pending_words.size() == 0)
         $display("** servo_slew_controller: PASSED **");
      else
         $display("** servo_slew_controller: FAILED **");
      $finish;
   end

endmodule
